[rtl/assert_macros.svh]
// Concurrent assertion helpers; clk and rst_n come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define LSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/lsh_pkg.sv]
`default_nettype none

package lsh_pkg;

    localparam int FRAME_LEN = 5;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_CONN = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    localparam logic [2:0] REG_ROLE          = 3'd0;
    localparam logic [2:0] REG_FLAG_BYTE     = 3'd1;
    localparam logic [2:0] REG_ADDR_SENDER   = 3'd2;
    localparam logic [2:0] REG_ADDR_ANSWER   = 3'd3;
    localparam logic [2:0] REG_CTRL_SETUP    = 3'd4;
    localparam logic [2:0] REG_CTRL_ACK      = 3'd5;
    localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd6;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd7;

    typedef enum logic [4:0] {
        M_START = 5'b00001,
        M_FLAG  = 5'b00010,
        M_ADDR  = 5'b00100,
        M_CTRL  = 5'b01000,
        M_CHECK = 5'b10000
    } match_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WAIT = 4'b0010,
        PH_CONN = 4'b0100,
        PH_FAIL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [1:0] link_status;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

[rtl/lsh_chan_if.sv]
`default_nettype none

interface lsh_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/link_setup_handshake.sv]
//  channel  | direction | word        | handshake
//  ---------+-----------+-------------+-----------------------------
//  item     | in        | cmd,rx_byte | valid/ready
//  result   | out       | frame byte  | valid/ready, last ends item
//  apb      | in        | 8 registers | psel/penable, pready high
//
// An item is taken and its state update is done on accept.
// It then yields one word, or five words for a frame, one per cycle while
// result is ready; the result sequencer steps through the words.
// The next item is taken in the cycle the last word leaves.
// rst_n clears the link state and the registers to their defaults.
// Stalls on result hold the current word; item waits meanwhile.
`default_nettype none

`include "assert_macros.svh"

module link_setup_handshake
    import lsh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lsh_chan_if.sink         item,
    lsh_chan_if.source       result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic        role_reg;
    logic [7:0]  flag_byte_reg;
    logic [7:0]  addr_sender_reg;
    logic [7:0]  addr_answer_reg;
    logic [7:0]  ctrl_setup_reg;
    logic [7:0]  ctrl_ack_reg;
    logic [3:0]  attempt_limit_reg;
    logic [15:0] timeout_ticks_reg;

    match_t      match_reg, match_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  timeouts_reg, timeouts_next;
    logic [15:0] tick_reg, tick_next;

    logic        pend_reg;
    logic        frame_reg, frame_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  flag_reg;
    logic [1:0]  status_reg;
    logic [2:0]  idx_reg;

    logic        cfg_write;
    logic        in_fire;
    logic        out_fire;
    logic        out_last;
    logic [7:0]  tx_byte_sel;
    logic [7:0]  exp_addr;
    logic [7:0]  exp_ctrl;
    logic        frame_done;
    logic [15:0] tick_inc;
    logic [3:0]  timeouts_sat;
    logic [1:0]  status_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg          <= 1'b0;
            flag_byte_reg     <= 8'd126;
            addr_sender_reg   <= 8'd3;
            addr_answer_reg   <= 8'd1;
            ctrl_setup_reg    <= 8'd3;
            ctrl_ack_reg      <= 8'd7;
            attempt_limit_reg <= 4'd4;
            timeout_ticks_reg <= 16'd3;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_ROLE:          role_reg          <= pwdata[0];
                REG_FLAG_BYTE:     flag_byte_reg     <= pwdata[7:0];
                REG_ADDR_SENDER:   addr_sender_reg   <= pwdata[7:0];
                REG_ADDR_ANSWER:   addr_answer_reg   <= pwdata[7:0];
                REG_CTRL_SETUP:    ctrl_setup_reg    <= pwdata[7:0];
                REG_CTRL_ACK:      ctrl_ack_reg      <= pwdata[7:0];
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= pwdata[3:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default:           role_reg          <= role_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ROLE:          prdata = {31'd0, role_reg};
            REG_FLAG_BYTE:     prdata = {24'd0, flag_byte_reg};
            REG_ADDR_SENDER:   prdata = {24'd0, addr_sender_reg};
            REG_ADDR_ANSWER:   prdata = {24'd0, addr_answer_reg};
            REG_CTRL_SETUP:    prdata = {24'd0, ctrl_setup_reg};
            REG_CTRL_ACK:      prdata = {24'd0, ctrl_ack_reg};
            REG_ATTEMPT_LIMIT: prdata = {28'd0, attempt_limit_reg};
            REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // result sequencer
    assign out_last   = !frame_reg || (idx_reg == 3'(FRAME_LEN - 1));
    assign out_fire   = pend_reg && result.ready;
    assign item.ready = !pend_reg || (out_fire && out_last);
    assign in_fire    = item.valid && item.ready;

    assign result.valid = pend_reg;
    assign result.data  = {tx_byte_sel, frame_reg, status_reg, out_last};

    always_comb
    begin
        tx_byte_sel = 8'd0;
        if (frame_reg)
        begin
            case (idx_reg)
                3'd0:    tx_byte_sel = flag_reg;
                3'd1:    tx_byte_sel = addr_reg;
                3'd2:    tx_byte_sel = ctrl_reg;
                3'd3:    tx_byte_sel = addr_reg ^ ctrl_reg;
                default: tx_byte_sel = flag_reg;
            endcase
        end
    end

    // link state update for the incoming word
    assign exp_addr     = role_reg ? addr_sender_reg : addr_answer_reg;
    assign exp_ctrl     = role_reg ? ctrl_setup_reg : ctrl_ack_reg;
    assign tick_inc     = tick_reg + 16'd1;
    assign timeouts_sat = (timeouts_reg == 4'hF) ? 4'hF : timeouts_reg + 4'd1;

    always_comb
    begin
        frame_done = 1'b0;
        match_next = match_reg;
        unique case (match_reg)
            M_START:
            begin
                if (item.data.rx_byte == flag_byte_reg)
                    match_next = M_FLAG;
            end
            M_FLAG:
            begin
                if (item.data.rx_byte == exp_addr)
                    match_next = M_ADDR;
                else if (item.data.rx_byte != flag_byte_reg)
                    match_next = M_START;
            end
            M_ADDR:
            begin
                if (item.data.rx_byte == exp_ctrl)
                    match_next = M_CTRL;
                else if (item.data.rx_byte == flag_byte_reg)
                    match_next = M_FLAG;
                else
                    match_next = M_START;
            end
            M_CTRL:
            begin
                if (item.data.rx_byte == (exp_addr ^ exp_ctrl))
                    match_next = M_CHECK;
                else if (item.data.rx_byte == flag_byte_reg)
                    match_next = M_FLAG;
                else
                    match_next = M_START;
            end
            M_CHECK:
            begin
                match_next = M_START;
                frame_done = (item.data.rx_byte == flag_byte_reg);
            end
            default: match_next = M_START;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        timeouts_next = timeouts_reg;
        tick_next     = tick_reg;
        frame_next    = 1'b0;
        addr_next     = addr_sender_reg;
        ctrl_next     = ctrl_setup_reg;
        case (item.data.cmd)
            CMD_START:
            begin
                timeouts_next = 4'd0;
                tick_next     = 16'd0;
                phase_next    = PH_WAIT;
                frame_next    = !role_reg;
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_WAIT && frame_done)
                begin
                    phase_next = PH_CONN;
                    frame_next = role_reg;
                    addr_next  = addr_answer_reg;
                    ctrl_next  = ctrl_ack_reg;
                end
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_WAIT && !role_reg)
                begin
                    if (tick_inc >= timeout_ticks_reg)
                    begin
                        tick_next     = 16'd0;
                        timeouts_next = timeouts_sat;
                        if (timeouts_sat >= attempt_limit_reg)
                            phase_next = PH_FAIL;
                        else
                            frame_next = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_comb
    begin
        unique case (phase_next)
            PH_IDLE: status_next = ST_IDLE;
            PH_WAIT: status_next = ST_WAIT;
            PH_CONN: status_next = ST_CONN;
            PH_FAIL: status_next = ST_FAIL;
            default: status_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= M_START;
            phase_reg    <= PH_IDLE;
            timeouts_reg <= 4'd0;
            tick_reg     <= 16'd0;
        end
        else if (in_fire)
        begin
            if (item.data.cmd == CMD_START)
                match_reg <= M_START;
            else if (item.data.cmd == CMD_BYTE && phase_reg == PH_WAIT)
                match_reg <= match_next;
            phase_reg    <= phase_next;
            timeouts_reg <= timeouts_next;
            tick_reg     <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (in_fire)
        begin
            pend_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end
        else if (out_fire)
        begin
            if (out_last)
                pend_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            frame_reg  <= frame_next;
            addr_reg   <= addr_next;
            ctrl_reg   <= ctrl_next;
            flag_reg   <= flag_byte_reg;
            status_reg <= status_next;
        end
    end

    `LSH_ASSERT_NEXT(a_accept_shows_word, in_fire, result.valid)
    `LSH_ASSERT_NEXT(a_frame_holds, pend_reg && !out_last, pend_reg)
    `LSH_ASSERT_NOW(a_empty_is_last, result.valid && !result.data.tx_valid, result.data.last)

endmodule

`default_nettype wire
